// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, switched off while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, but also evaluated during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/utf8_pkg.sv =====
// Constants and types for the UTF-8 stream decoder.
package utf8_pkg;

    localparam int CP_W  = 21;
    localparam int CNT_W = 3;

    localparam logic [CP_W-1:0] REPL_CP   = 21'h00FFFD;
    localparam logic [CP_W-1:0] MAX_CP    = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI   = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_2BYTE = 21'h000080;
    localparam logic [CP_W-1:0] MIN_3BYTE = 21'h000800;
    localparam logic [CP_W-1:0] MIN_4BYTE = 21'h010000;

    localparam logic [1:0] NEED_NONE = 2'd0;
    localparam logic [1:0] NEED_ONE  = 2'd1;
    localparam logic [1:0] NEED_TWO  = 2'd2;
    localparam logic [1:0] NEED_THREE = 2'd3;

    localparam logic [CNT_W-1:0] RUN_MAX = 3'd4;

    // Pending output run: some replacements, then an optional decoded value.
    typedef struct packed {
        logic [CNT_W-1:0] rep_cnt;
        logic             tail_valid;
        logic [CP_W-1:0]  tail_cp;
    } run_t;

endpackage

// ===== sv/utf8_stream_decoder_top.sv =====
// UTF-8 stream decoder: bytes in, code points (or U+FFFD) out.
//
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------
//  in      | in_valid/in_stall  | in_byte[7:0], last_byte
//  out     | out_valid/out_stall| code_point[20:0], is_replacement, run_end
//
// One byte is taken per cycle while in_stall is low; the sequence state and
// the output run register are updated in the same cycle the request is accepted.
// A byte yielding results holds the input until they leave; one yielding none
// does not. The run register hands out one result per cycle while out_stall is
// low, and the next byte is taken in the cycle its last result leaves.
// rst_n (async, active low) clears the sequence state and empties the run.
// An output stall freezes the run; input stalls only while a run remains.
module utf8_stream_decoder_top
    import utf8_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [7:0]      in_byte,
    input  logic            last_byte,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [CP_W-1:0] code_point,
    output logic            is_replacement,
    output logic            run_end
);

`include "assert_macros.svh"

    // Sequence state
    logic [1:0]      need_reg, need_next;
    logic [1:0]      have_reg, have_next;
    logic [CP_W-1:0] partial_reg, partial_next;

    // Output run
    run_t run_reg, run_next;
    run_t run_new;

    logic in_take;
    logic out_take;

    // ------------------------------------------------------------------
    // Output side: replacements first, then the decoded value if any.
    // ------------------------------------------------------------------
    assign out_valid      = (run_reg.rep_cnt != '0) || run_reg.tail_valid;
    assign code_point     = (run_reg.rep_cnt != '0) ? REPL_CP : run_reg.tail_cp;
    assign is_replacement = (run_reg.rep_cnt != '0);
    assign run_end        = (run_reg.rep_cnt == '0) ||
                            ((run_reg.rep_cnt == 3'd1) && !run_reg.tail_valid);

    assign out_take = out_valid && !out_stall;

    // Take a new byte once the run is empty or its final result leaves now.
    assign in_stall = out_valid && !(run_end && !out_stall);
    assign in_take  = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Decode
    // ------------------------------------------------------------------
    logic            is_cont;
    logic            pending;
    logic [CP_W-1:0] acc_val;
    logic [1:0]      have_inc;
    logic            acc_ok;
    logic [1:0]      fresh_need;
    logic [CP_W-1:0] fresh_bits;

    assign is_cont  = (in_byte[7:6] == 2'b10);
    assign pending  = (need_reg != NEED_NONE);
    assign acc_val  = {partial_reg[CP_W-7:0], in_byte[5:0]};
    assign have_inc = have_reg + 2'd1;

    always_comb
    begin
        case (need_reg)
            NEED_ONE:   acc_ok = (acc_val >= MIN_2BYTE);
            NEED_TWO:   acc_ok = (acc_val >= MIN_3BYTE) &&
                                 !((acc_val >= SURR_LO) && (acc_val <= SURR_HI));
            NEED_THREE: acc_ok = (acc_val >= MIN_4BYTE) && (acc_val <= MAX_CP);
            default:    acc_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        fresh_need = NEED_NONE;
        fresh_bits = '0;
        if (in_byte[7:5] == 3'b110)
        begin
            fresh_need = NEED_ONE;
            fresh_bits = {16'd0, in_byte[4:0]};
        end
        else if (in_byte[7:4] == 4'b1110)
        begin
            fresh_need = NEED_TWO;
            fresh_bits = {17'd0, in_byte[3:0]};
        end
        else if (in_byte[7:3] == 5'b11110)
        begin
            fresh_need = NEED_THREE;
            fresh_bits = {18'd0, in_byte[2:0]};
        end
    end

    always_comb
    begin
        need_next    = need_reg;
        have_next    = have_reg;
        partial_next = partial_reg;
        run_new      = '0;

        if (pending && is_cont)
        begin
            partial_next = acc_val;
            have_next    = have_inc;
            if (have_inc == need_reg)
            begin
                if (acc_ok)
                begin
                    run_new.tail_valid = 1'b1;
                    run_new.tail_cp    = acc_val;
                end
                else
                begin
                    run_new.rep_cnt = 3'd1 + {1'b0, have_inc};
                end
                need_next    = NEED_NONE;
                have_next    = '0;
                partial_next = '0;
            end
            else if (last_byte)
            begin
                run_new.rep_cnt = 3'd1 + {1'b0, have_inc};
            end
        end
        else
        begin
            // no sequence pending or a broken one: flush what is held, then decode this byte fresh
            if (pending)
            begin
                run_new.rep_cnt = 3'd1 + {1'b0, have_reg};
                need_next    = NEED_NONE;
                have_next    = '0;
                partial_next = '0;
            end
            if (!in_byte[7])
            begin
                run_new.tail_valid = 1'b1;
                run_new.tail_cp    = {13'd0, in_byte};
            end
            else if ((fresh_need == NEED_NONE) || last_byte)
            begin
                run_new.rep_cnt = run_new.rep_cnt + 3'd1;
            end
            else
            begin
                need_next    = fresh_need;
                have_next    = '0;
                partial_next = fresh_bits;
            end
        end

        // end of string always drops the sequence
        if (last_byte)
        begin
            need_next    = NEED_NONE;
            have_next    = '0;
            partial_next = '0;
        end
    end

    // ------------------------------------------------------------------
    // Run register advance
    // ------------------------------------------------------------------
    always_comb
    begin
        run_next = run_reg;
        if (in_take)
        begin
            run_next = run_new;
        end
        else if (out_take)
        begin
            if (run_reg.rep_cnt != '0)
                run_next.rep_cnt = run_reg.rep_cnt - 3'd1;
            else
                run_next.tail_valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            need_reg    <= NEED_NONE;
            have_reg    <= '0;
            partial_reg <= '0;
            run_reg     <= '0;
        end
        else
        begin
            if (in_take)
            begin
                need_reg    <= need_next;
                have_reg    <= have_next;
                partial_reg <= partial_next;
            end
            run_reg <= run_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_CLK(a_run_size, (({1'b0, run_reg.rep_cnt} + {3'd0, run_reg.tail_valid}) <= {1'b0, RUN_MAX}), "run longer than four results")
    `ASSERT_CLK(a_have_below_need, (need_reg != NEED_NONE) |-> (have_reg < need_reg), "continuation count reached need without completing")
    `ASSERT_CLK(a_last_clears, (in_take && last_byte) |=> (need_reg == NEED_NONE), "sequence still pending after end of string")

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the UTF-8 stream decoder: directed and random byte streams.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import utf8_pkg::*;

    // Byte classes of UTF-8: mask and tag pairs.
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_TAG    = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_TAG   = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_TAG   = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_TAG   = 8'hF0;

    localparam int IDLE_MAX     = 3;
    localparam int RANDOM_BYTES = 170;
    localparam int TAIL_CYCLES  = 20;
    localparam int MAX_REPORTS  = 10;

    // One request on the input channel, one result on the output channel.
    typedef struct packed {
        logic [7:0] value;
        logic       fin;
    } byte_req_t;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            repl;
        logic            fin;
    } cp_result_t;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            in_valid  = 1'b0;
    logic            in_stall;
    logic [7:0]      in_byte   = 8'h00;
    logic            last_byte = 1'b0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    logic [CP_W-1:0] code_point;
    logic            is_replacement;
    logic            run_end;

    byte_req_t  byte_q[$];       // requests not yet presented
    cp_result_t cp_expect_q[$];  // predicted code points, oldest first
    cp_result_t run_q[$];        // results of the byte being decoded

    // Decoder state as the predictor tracks it.
    logic [7:0]      seq_lead = '0;
    logic [1:0]      seq_need = NEED_NONE;
    logic [1:0]      seq_have = '0;
    logic [CP_W-1:0] seq_bits = '0;

    int errors   = 0;
    int in_idle  = 0;
    int out_idle = 0;
    bit in_calm  = 1'b0;   // while set, requests go back to back
    bit out_calm = 1'b0;   // while set, results are never stalled

    utf8_stream_decoder_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .code_point     (code_point),
        .is_replacement (is_replacement),
        .run_end        (run_end)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void clear_seq();
        seq_lead = '0;
        seq_need = NEED_NONE;
        seq_have = '0;
        seq_bits = '0;
    endfunction

    function automatic void add_result(logic [CP_W-1:0] cp, logic repl, int count);
        for (int i = 0; i < count; i++)
            run_q.insert(run_q.size(), cp_result_t'({cp, repl, 1'b0}));
    endfunction

    // A byte seen with nothing pending: ASCII, a lead, or garbage.
    // A lead that is also the last byte of the string is cut off at once.
    function automatic void open_byte(logic [7:0] b, logic fin);
        logic [1:0]      need;
        logic [CP_W-1:0] bits;
        need = NEED_NONE;
        bits = '0;
        if (b < ASCII_LIMIT)
        begin
            add_result(CP_W'(b), 1'b0, 1);
        end
        else
        begin
            if ((b & LEAD2_MASK) == LEAD2_TAG)
            begin
                need = NEED_ONE;
                bits = CP_W'(b[4:0]);
            end
            else if ((b & LEAD3_MASK) == LEAD3_TAG)
            begin
                need = NEED_TWO;
                bits = CP_W'(b[3:0]);
            end
            else if ((b & LEAD4_MASK) == LEAD4_TAG)
            begin
                need = NEED_THREE;
                bits = CP_W'(b[2:0]);
            end
            if (need == NEED_NONE || fin)
            begin
                add_result(REPL_CP, 1'b1, 1);
            end
            else
            begin
                seq_lead = b;
                seq_need = need;
                seq_have = '0;
                seq_bits = bits;
            end
        end
    endfunction

    // Works out every result one accepted byte causes and queues them,
    // run_end set on the last of the run.
    function automatic void decode_byte(logic [7:0] b, logic fin);
        logic       ok;
        cp_result_t r;
        run_q.delete();
        if (seq_need == NEED_NONE)
        begin
            open_byte(b, fin);
        end
        else if ((b & CONT_MASK) != CONT_TAG)
        begin
            // broken sequence: flush held bytes, then decode this one afresh
            add_result(REPL_CP, 1'b1, 1 + seq_have);
            clear_seq();
            open_byte(b, fin);
        end
        else
        begin
            seq_bits = {seq_bits[CP_W-7:0], b[5:0]};
            seq_have = seq_have + 2'd1;
            if (seq_have == seq_need)
            begin
                case (seq_need)
                    NEED_ONE: ok = (seq_bits >= MIN_2BYTE);
                    NEED_TWO: ok = (seq_bits >= MIN_3BYTE) &&
                                   !(seq_bits >= SURR_LO && seq_bits <= SURR_HI);
                    default:  ok = (seq_bits >= MIN_4BYTE) && (seq_bits <= MAX_CP);
                endcase
                if (ok)
                    add_result(seq_bits, 1'b0, 1);
                else
                    add_result(REPL_CP, 1'b1, 1 + seq_have);
                clear_seq();
            end
            else if (fin)
            begin
                add_result(REPL_CP, 1'b1, 1 + seq_have);
                clear_seq();
            end
        end
        if (fin)
            clear_seq();
        foreach (run_q[i])
        begin
            r = run_q[i];
            r.fin = (i == run_q.size() - 1);
            cp_expect_q.insert(cp_expect_q.size(), r);
        end
    endfunction

    function automatic void log_mismatch(string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function automatic int idle_draw(bit calm);
        return calm ? 0 : $urandom_range(0, IDLE_MAX);
    endfunction

    // Encodes cp in len bytes (overlong if cp is small) and queues the
    // first keep of them; fin marks the last queued byte as end of string.
    function automatic void queue_seq(logic [CP_W-1:0] cp, int len, int keep, bit fin);
        logic [7:0] b;
        for (int i = 0; i < keep; i++)
        begin
            if (i > 0)
                b = {2'b10, cp[6*(len-1-i) +: 6]};
            else
                case (len)
                    1:       b = {1'b0, cp[6:0]};
                    2:       b = {3'b110, cp[10:6]};
                    3:       b = {4'b1110, cp[15:12]};
                    default: b = {5'b11110, cp[20:18]};
                endcase
            byte_q.insert(byte_q.size(), byte_req_t'({b, fin && (i == keep - 1)}));
        end
    endfunction

    // ------------------------------------------------------------------
    // Request driver: presents queued bytes, may idle between requests,
    // and holds the payload steady while the decoder stalls.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : req_driver
        byte_req_t req;
        int        gap;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_byte   <= 8'h00;
            last_byte <= 1'b0;
            in_idle   <= 0;
        end
        else if (!(in_valid && in_stall))
        begin
            if ($urandom_range(0, 31) == 0)
                in_calm <= !in_calm;
            // a request just went through: draw the idle before the next one
            gap = in_valid ? idle_draw(in_calm) : in_idle;
            if (gap == 0 && byte_q.size() != 0)
            begin
                req = byte_q.pop_front();
                in_valid  <= 1'b1;
                in_byte   <= req.value;
                last_byte <= req.fin;
            end
            else
            begin
                in_valid <= 1'b0;
                in_idle  <= (gap > 0) ? gap - 1 : 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink: after each accepted result, may stall before taking the next one.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : result_sink
        int gap;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_idle  <= 0;
        end
        else
        begin
            if ($urandom_range(0, 31) == 0)
                out_calm <= !out_calm;
            if (out_stall)
            begin
                if (out_idle == 0)
                    out_stall <= 1'b0;
                else
                    out_idle <= out_idle - 1;
            end
            else if (out_valid)
            begin
                gap = idle_draw(out_calm);
                if (gap > 0)
                begin
                    out_stall <= 1'b1;
                    out_idle  <= gap - 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on each accepted request, then checks the
    // accepted result. Both in one block, prediction first, so each
    // result finds the expectation queued when its byte was accepted.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        cp_result_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                decode_byte(in_byte, last_byte);
            if (out_valid && !out_stall)
            begin
                if (cp_expect_q.size() == 0)
                begin
                    log_mismatch($sformatf("unexpected result cp=%h repl=%b end=%b",
                                           code_point, is_replacement, run_end));
                end
                else
                begin
                    want = cp_expect_q.pop_front();
                    if (code_point !== want.cp || is_replacement !== want.repl ||
                        run_end !== want.fin)
                        log_mismatch($sformatf(
                            "cp exp %h got %h, repl exp %b got %b, end exp %b got %b",
                            want.cp, code_point, want.repl, is_replacement,
                            want.fin, run_end));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int              kind;
        int              len;
        int              keep;
        int              base;
        bit              fin;
        logic [CP_W-1:0] cp;
        logic [CP_W-1:0] lo;
        logic [CP_W-1:0] hi;

        // Directed: field extremes and each rejection path.
        queue_seq(21'h000000, 1, 1, 1'b0);      // NUL
        queue_seq(21'h00007F, 1, 1, 1'b1);      // top of ASCII, ends a string
        queue_seq(REPL_CP, 3, 3, 1'b0);         // well-formed U+FFFD, not a replacement
        queue_seq(MAX_CP, 4, 4, 1'b1);          // largest scalar, ends a string
        queue_seq(21'h000000, 2, 2, 1'b0);      // overlong, lead 0xC0
        queue_seq(SURR_LO, 3, 3, 1'b0);         // surrogate
        queue_seq(CP_W'(MAX_CP + 1), 4, 4, 1'b0);   // above range: four replacements
        byte_q.insert(byte_q.size(), byte_req_t'({8'h80, 1'b0}));   // stray continuation
        byte_q.insert(byte_q.size(), byte_req_t'({8'hFF, 1'b0}));   // never a lead
        byte_q.insert(byte_q.size(), byte_req_t'({8'hF8, 1'b0}));
        queue_seq(21'h0020AC, 3, 1, 1'b0);      // lead broken by ASCII
        byte_q.insert(byte_q.size(), byte_req_t'({8'h41, 1'b0}));
        queue_seq(21'h0020AC, 3, 2, 1'b1);      // cut off by end of string
        queue_seq(21'h0020AC, 3, 2, 1'b0);      // broken by a new lead
        queue_seq(21'h0000E9, 2, 2, 1'b0);

        // Random: mostly well-formed sequences, some invalid or truncated,
        // some raw noise bytes.
        base = byte_q.size();
        while (byte_q.size() - base < RANDOM_BYTES)
        begin
            kind = $urandom_range(0, 15);
            len  = $urandom_range(1, 4);
            fin  = ($urandom_range(0, 5) == 0);
            case (len)
                1:
                begin
                    lo = '0;
                    hi = CP_W'(MIN_2BYTE - 1);
                end
                2:
                begin
                    lo = MIN_2BYTE;
                    hi = CP_W'(MIN_3BYTE - 1);
                end
                3:
                begin
                    lo = MIN_3BYTE;
                    hi = CP_W'(MIN_4BYTE - 1);
                end
                default:
                begin
                    lo = MIN_4BYTE;
                    hi = MAX_CP;
                end
            endcase
            if ($urandom_range(0, 3) == 0)
                cp = $urandom_range(0, 1) ? lo : hi;
            else
                cp = CP_W'($urandom_range(lo, hi));
            keep = len;
            if (kind == 10 && len > 1)
            begin
                cp = CP_W'($urandom_range(0, lo - 1));     // overlong
            end
            else if (kind == 11)
            begin
                if ($urandom_range(0, 1))
                begin
                    len = 3;
                    cp  = CP_W'($urandom_range(SURR_LO, SURR_HI));
                end
                else
                begin
                    len = 4;
                    cp  = CP_W'($urandom_range(MAX_CP + 1, {CP_W{1'b1}}));
                end
                keep = len;
            end
            else if (kind == 12 && len > 1)
            begin
                keep = $urandom_range(1, len - 1);  // truncated
            end

            if (kind >= 13)
                byte_q.insert(byte_q.size(),
                              byte_req_t'({8'($urandom_range(0, 255)), fin}));
            else
                queue_seq(cp, len, keep, fin);
        end

        repeat (7) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // Drain: every byte presented and every predicted result seen.
        do
            @(negedge clk);
        while (byte_q.size() != 0 || in_valid || cp_expect_q.size() != 0);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("PASS utf8_stream_decoder_top");
        else
            $display("FAIL utf8_stream_decoder_top");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin : watchdog
        #2000000;
        $display("FAIL utf8_stream_decoder_top");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/utf8_pkg.sv
sv/utf8_stream_decoder_top.sv
verif/testbench.sv
